### rtl/burh_pkg.sv
`timescale 1ns / 1ps
package burh_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SNAP_WIDTH  = 32;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int SUM_W       = CNT_W + 1;
	localparam int LIMIT_W     = 7;
	localparam int ENTRY_W     = 7;
	localparam int WORD_W      = 32;
	localparam int CMD_W       = 3;

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [SNAP_WIDTH-1:0] snap_t;
	typedef logic [LIMIT_W-1:0]    limit_t;

	localparam limit_t LIMIT_RESET = limit_t'(64);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 3'd0,
		CMD_UNDO  = 3'd1,
		CMD_REDO  = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_TRIM  = 3'd4,
		CMD_SET   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		RING_HOLD,
		RING_PUSH,
		RING_POP,
		RING_CLEAR,
		RING_TRIM
	} ring_op_t;

	typedef struct packed {
		ring_op_t op;
		snap_t    wdata;
	} ring_ctl_t;

	// A limit above the ring depth behaves as the ring depth.
	function automatic cnt_t eff_limit(limit_t lim);
		if (int'(lim) > STACK_DEPTH) begin
			return cnt_t'(STACK_DEPTH);
		end
		return cnt_t'(lim);
	endfunction

	// Pointer plus offset, wrapped once around the ring.
	function automatic ptr_t ring_add(ptr_t p, cnt_t c);
		sum_t s;
		s = sum_t'(p) + sum_t'(c);
		if (s >= sum_t'(STACK_DEPTH)) begin
			s = s - sum_t'(STACK_DEPTH);
		end
		return ptr_t'(s);
	endfunction

endpackage

### rtl/burh_ring.sv
`timescale 1ns / 1ps
module burh_ring (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  burh_pkg::ring_ctl_t ctl,
	input  burh_pkg::cnt_t      lim,
	output burh_pkg::snap_t     rd_data,
	output burh_pkg::cnt_t      count
);

	burh_pkg::snap_t store [burh_pkg::STACK_DEPTH];
	burh_pkg::snap_t rdata_s1;
	burh_pkg::ptr_t  oldest_q;
	burh_pkg::cnt_t  count_q;

	burh_pkg::ptr_t  top_addr;
	burh_pkg::ptr_t  wr_addr;
	burh_pkg::ptr_t  push_oldest;
	burh_pkg::cnt_t  push_count;
	logic            drop_oldest;
	logic            push_en;

	// The newest entry sits just below oldest + count.
	assign top_addr = burh_pkg::ring_add(oldest_q, count_q - burh_pkg::cnt_t'(1));

	// A full stack loses its oldest entry before the new one goes in.
	assign drop_oldest = (count_q >= lim);
	assign push_oldest = drop_oldest ? burh_pkg::ring_add(oldest_q, burh_pkg::cnt_t'(1))
	                                 : oldest_q;
	assign push_count  = drop_oldest ? count_q - burh_pkg::cnt_t'(1) : count_q;
	assign wr_addr     = burh_pkg::ring_add(push_oldest, push_count);
	assign push_en     = (ctl.op == burh_pkg::RING_PUSH) && (lim != '0);

	always_ff @(posedge clk) begin
		if (push_en) begin
			store[wr_addr] <= ctl.wdata;
		end
		if (rd_en) begin
			rdata_s1 <= store[top_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (ctl.op)
				burh_pkg::RING_PUSH: begin
					if (lim == '0) begin
						oldest_q <= '0;
						count_q  <= '0;
					end else begin
						oldest_q <= push_oldest;
						count_q  <= push_count + burh_pkg::cnt_t'(1);
					end
				end
				burh_pkg::RING_POP: begin
					if (count_q != '0) begin
						count_q <= count_q - burh_pkg::cnt_t'(1);
					end
				end
				burh_pkg::RING_CLEAR: begin
					oldest_q <= '0;
					count_q  <= '0;
				end
				burh_pkg::RING_TRIM: begin
					if (lim == '0) begin
						oldest_q <= '0;
						count_q  <= '0;
					end else if (count_q > lim) begin
						oldest_q <= burh_pkg::ring_add(oldest_q, count_q - lim);
						count_q  <= lim;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_data = rdata_s1;
	assign count   = count_q;

endmodule

### rtl/bounded_undo_redo_history.sv
// A command taken at a clock edge is executed in the EXEC state; its word is
// registered there and shown on the result ports, marked by done for one cycle.
// A new command is not taken while busy; busy is high for the one cycle in
// which the stack top read in the accept cycle is used and written back.
// Reset: both stacks empty, current word zero, history limit 64. The stack
// memories themselves are not cleared; entries are used only after written.
`timescale 1ns / 1ps
module bounded_undo_redo_history (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] snapshot_word,
	output logic        done,
	output logic [31:0] current_word,
	output logic [6:0]  undo_entries,
	output logic [6:0]  redo_entries,
	output logic        moved,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	// Two states: IDLE takes a command and launches the read of both stack
	// tops; EXEC consumes the read data, writes the rings and updates the
	// current word. Results are shown from the updated state in the cycle
	// after EXEC, when the block is already idle and can take the next word.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                 state_q;
	burh_pkg::cmd_t         cmd_q;
	burh_pkg::snap_t        word_q;
	burh_pkg::snap_t        current_q;
	burh_pkg::limit_t       limit_q;
	logic                   done_q;
	logic                   moved_q;

	logic                   accept;
	burh_pkg::cnt_t         lim;
	burh_pkg::ring_ctl_t    undo_ctl;
	burh_pkg::ring_ctl_t    redo_ctl;
	burh_pkg::snap_t        undo_top;
	burh_pkg::snap_t        redo_top;
	burh_pkg::cnt_t         undo_count;
	burh_pkg::cnt_t         redo_count;
	burh_pkg::snap_t        current_d;
	logic                   moved_d;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q == ST_EXEC);
	assign cfg_ready = (state_q == ST_IDLE);
	assign lim       = burh_pkg::eff_limit(limit_q);

	// Both tops are read on every accepted command; the pointers are settled
	// by then because the previous command finished its write-back in EXEC.
	burh_ring u_undo (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ctl     (undo_ctl),
		.lim     (lim),
		.rd_data (undo_top),
		.count   (undo_count)
	);

	burh_ring u_redo (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ctl     (redo_ctl),
		.lim     (lim),
		.rd_data (redo_top),
		.count   (redo_count)
	);

	// Command decode for the EXEC cycle. Undo and redo move the current word
	// onto the opposite stack and take the popped top as the new current word;
	// on an empty source stack nothing changes.
	always_comb begin
		undo_ctl.op    = burh_pkg::RING_HOLD;
		undo_ctl.wdata = current_q;
		redo_ctl.op    = burh_pkg::RING_HOLD;
		redo_ctl.wdata = current_q;
		current_d      = current_q;
		moved_d        = 1'b0;
		if (state_q == ST_EXEC) begin
			unique case (cmd_q)
				burh_pkg::CMD_PUSH: begin
					undo_ctl.op    = burh_pkg::RING_PUSH;
					undo_ctl.wdata = word_q;
					redo_ctl.op    = burh_pkg::RING_CLEAR;
				end
				burh_pkg::CMD_UNDO: begin
					if (undo_count != '0) begin
						undo_ctl.op = burh_pkg::RING_POP;
						redo_ctl.op = burh_pkg::RING_PUSH;
						current_d   = undo_top;
						moved_d     = 1'b1;
					end
				end
				burh_pkg::CMD_REDO: begin
					if (redo_count != '0) begin
						redo_ctl.op = burh_pkg::RING_POP;
						undo_ctl.op = burh_pkg::RING_PUSH;
						current_d   = redo_top;
						moved_d     = 1'b1;
					end
				end
				burh_pkg::CMD_CLEAR: begin
					undo_ctl.op = burh_pkg::RING_CLEAR;
					redo_ctl.op = burh_pkg::RING_CLEAR;
				end
				burh_pkg::CMD_TRIM: begin
					undo_ctl.op = burh_pkg::RING_TRIM;
					redo_ctl.op = burh_pkg::RING_TRIM;
				end
				burh_pkg::CMD_SET: begin
					current_d = word_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= burh_pkg::CMD_PUSH;
			word_q    <= '0;
			current_q <= '0;
			limit_q   <= burh_pkg::LIMIT_RESET;
			done_q    <= 1'b0;
			moved_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= burh_pkg::cmd_t'(cmd);
						word_q  <= burh_pkg::snap_t'(snapshot_word);
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					current_q <= current_d;
					moved_q   <= moved_d;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The ring counts and current word are already updated when done is high.
	assign done         = done_q;
	assign moved        = moved_q;
	assign current_word = burh_pkg::WORD_W'(current_q);
	assign undo_entries = burh_pkg::ENTRY_W'(undo_count);
	assign redo_entries = burh_pkg::ENTRY_W'(redo_count);

endmodule

### rtl/burh_check.sv
`timescale 1ns / 1ps
module burh_check (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  cmd,
	input logic        done,
	input logic [6:0]  undo_entries,
	input logic [6:0]  redo_entries,
	input logic        moved
);

	// Each accepted command occupies exactly one busy cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// The busy cycle is always followed by exactly one result word.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("busy cycle not followed by a result");

	// A clear leaves both stacks empty in its result.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == burh_pkg::CMD_CLEAR) |=> ##1
		(done && undo_entries == '0 && redo_entries == '0 && !moved))
		else $error("clear left entries behind");

	// Only undo and redo can report a restored snapshot.
	a_moved_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && moved) |->
		($past(cmd, 2) == burh_pkg::CMD_UNDO || $past(cmd, 2) == burh_pkg::CMD_REDO))
		else $error("moved set by a command other than undo or redo");

endmodule

bind bounded_undo_redo_history burh_check u_burh_check (.*);

### sim/bounded_undo_redo_history_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the bounded undo/redo history block.
//
// A command word goes in on start/busy and one result word comes back on done.
// The bench keeps its own copy of both history stacks, the current snapshot
// and the history limit. Every accepted command is applied to that copy and
// the resulting word is queued. Every done pulse is checked against the
// oldest queued word, field by field.
module bounded_undo_redo_history_test;

	// Command codes the block does not use; they must leave everything alone.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// Index of each stack in the shadow arrays.
	localparam int UNDO_SIDE = 0;
	localparam int REDO_SIDE = 1;

	// Random traffic flavors: mostly pushes, mostly undos, or a mix of all commands.
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PLAN_ROWS       = 24;
	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int SETTLE_CYCLES   = 4;

	typedef struct packed {
		logic [31:0] current;
		logic [6:0]  undo_n;
		logic [6:0]  redo_n;
		logic        moved;
	} history_result_t;

	// One row of the directed table. A config row carries the new limit in
	// the low bits of word. A row with typed set carries its own expected word.
	typedef struct packed {
		logic            cfg_row;
		logic [2:0]      op;
		logic [31:0]     word;
		logic            typed;
		history_result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  cmd = burh_pkg::CMD_PUSH;
	logic [31:0] snapshot_word = '0;
	logic        done;
	logic [31:0] current_word;
	logic [6:0]  undo_entries;
	logic [6:0]  redo_entries;
	logic        moved;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	bounded_undo_redo_history uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.snapshot_word(snapshot_word),
		.done         (done),
		.current_word (current_word),
		.undo_entries (undo_entries),
		.redo_entries (redo_entries),
		.moved        (moved),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the history: two rings with an oldest pointer and a fill
	// count each, the current snapshot and the limit register.
	logic [31:0]       hist_mem [2][burh_pkg::STACK_DEPTH];
	int                hist_head [2];
	int                hist_fill [2];
	logic [31:0]       hist_now;
	burh_pkg::limit_t  hist_limit;

	history_result_t pending_results [$];
	int              fail_count = 0;
	int              stall_cycles = 0;
	int              burst_left = 0;

	// Percent weights per traffic flavor, indexed by command code 0 to 7.
	int op_weight [3][8] = '{
		'{65, 10,  7, 1, 5,  8, 2, 2},
		'{10, 60, 10, 1, 4, 10, 3, 2},
		'{30, 25, 20, 3, 6, 10, 3, 3}
	};

	// Limits for the random phases; the last one is drawn at random. Zero,
	// one, the depth, just above it and the all-ones value are all visited.
	// The drop from 127 down to 1 and from 65 to 63 leaves stacks longer
	// than the limit, so trims and pushes onto an over-full stack get hit.
	int phase_limit [PHASES] = '{64, 0, 127, 127, 1, 2, 65, 63, 7, 100, 3, 0};
	int phase_mode  [PHASES] = '{
		MODE_FILL, MODE_DRAIN, MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_FILL,
		MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_FILL, MODE_MIX, MODE_MIX
	};

	// Directed part. Expected words are typed in where they are plain to see:
	// empty-stack undo and redo, the spare codes, the first few pushes and
	// moves at the reset limit. The rest goes through the shadow model.
	plan_row_t directed_plan [PLAN_ROWS] = '{
		// Undo and redo with both stacks empty change nothing.
		'{1'b0, burh_pkg::CMD_UNDO, 32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, 7'd0, 1'b0}},
		'{1'b0, burh_pkg::CMD_REDO, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 7'd0, 7'd0, 1'b0}},
		// Spare command codes are ignored.
		'{1'b0, CMD_SPARE_6, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 7'd0, 7'd0, 1'b0}},
		'{1'b0, CMD_SPARE_7, 32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, 7'd0, 1'b0}},
		'{1'b0, burh_pkg::CMD_SET, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 7'd0, 7'd0, 1'b0}},
		'{1'b0, burh_pkg::CMD_PUSH, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 7'd1, 7'd0, 1'b0}},
		'{1'b0, burh_pkg::CMD_PUSH, 32'hA5A5_A5A5, 1'b1, '{32'hFFFF_FFFF, 7'd2, 7'd0, 1'b0}},
		'{1'b0, burh_pkg::CMD_UNDO, 32'h0000_0000, 1'b1, '{32'hA5A5_A5A5, 7'd1, 7'd1, 1'b1}},
		'{1'b0, burh_pkg::CMD_UNDO, 32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, 7'd2, 1'b1}},
		'{1'b0, burh_pkg::CMD_REDO, 32'h0000_0000, 1'b1, '{32'hA5A5_A5A5, 7'd1, 7'd1, 1'b1}},
		'{1'b0, burh_pkg::CMD_SET, 32'h5A5A_5A5A, 1'b1, '{32'h5A5A_5A5A, 7'd1, 7'd1, 1'b0}},
		// A push throws away the redo stack.
		'{1'b0, burh_pkg::CMD_PUSH, 32'h1234_5678, 1'b1, '{32'h5A5A_5A5A, 7'd2, 7'd0, 1'b0}},
		'{1'b0, burh_pkg::CMD_TRIM, 32'h0000_0000, 1'b0, '0},
		// Lowering the limit alone shrinks nothing; the trim after it finds both stacks within it.
		'{1'b1, burh_pkg::CMD_PUSH, 32'h0000_0001, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_UNDO, 32'h0000_0000, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_TRIM, 32'h0000_0000, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_PUSH, 32'h0F0F_0F0F, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_PUSH, 32'hF0F0_F0F0, 1'b0, '0},
		// Zero limit: a move or push empties the stack it stores onto.
		'{1'b1, burh_pkg::CMD_PUSH, 32'h0000_0000, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_UNDO, 32'h0000_0000, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_PUSH, 32'hDEAD_BEEF, 1'b0, '0},
		// A limit above the stack depth acts as the depth.
		'{1'b1, burh_pkg::CMD_PUSH, 32'h0000_007F, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_PUSH, 32'h8000_0000, 1'b0, '0},
		'{1'b0, burh_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 1'b0, '0}
	};

	function automatic int effective_cap();
		return (int'(hist_limit) > burh_pkg::STACK_DEPTH) ? burh_pkg::STACK_DEPTH
			: int'(hist_limit);
	endfunction

	function automatic void stack_empty(int side);
		hist_head[side] = 0;
		hist_fill[side] = 0;
	endfunction

	function automatic void stack_drop_oldest(int side);
		if (hist_fill[side] == 0) begin
			return;
		end
		hist_head[side] = (hist_head[side] + 1) % burh_pkg::STACK_DEPTH;
		hist_fill[side]--;
	endfunction

	// Store on top; a full stack loses its oldest entry first, and a zero
	// limit leaves the stack empty instead.
	function automatic void stack_store(int side, logic [31:0] w);
		int cap;
		cap = effective_cap();
		if (cap == 0) begin
			stack_empty(side);
			return;
		end
		if (hist_fill[side] >= cap) begin
			stack_drop_oldest(side);
		end
		if (hist_fill[side] >= burh_pkg::STACK_DEPTH) begin
			stack_drop_oldest(side);
		end
		hist_mem[side][(hist_head[side] + hist_fill[side]) % burh_pkg::STACK_DEPTH] = w;
		hist_fill[side]++;
	endfunction

	function automatic void stack_trim(int side);
		int cap;
		cap = effective_cap();
		if (cap == 0) begin
			stack_empty(side);
			return;
		end
		while (hist_fill[side] > cap) begin
			stack_drop_oldest(side);
		end
	endfunction

	// Undo or redo: pop one stack, save the current word on the other one and
	// make the popped word current. Returns whether anything was restored.
	function automatic logic stack_shift(int src, int dst);
		logic [31:0] top;
		if (hist_fill[src] == 0) begin
			return 1'b0;
		end
		top = hist_mem[src][(hist_head[src] + hist_fill[src] - 1) % burh_pkg::STACK_DEPTH];
		hist_fill[src]--;
		stack_store(dst, hist_now);
		hist_now = top;
		return 1'b1;
	endfunction

	function automatic history_result_t apply_command(logic [2:0] op, logic [31:0] w);
		history_result_t r;
		logic            restored;
		restored = 1'b0;
		case (op)
			burh_pkg::CMD_PUSH: begin
				stack_store(UNDO_SIDE, w);
				stack_empty(REDO_SIDE);
			end
			burh_pkg::CMD_UNDO: restored = stack_shift(UNDO_SIDE, REDO_SIDE);
			burh_pkg::CMD_REDO: restored = stack_shift(REDO_SIDE, UNDO_SIDE);
			burh_pkg::CMD_CLEAR: begin
				stack_empty(UNDO_SIDE);
				stack_empty(REDO_SIDE);
			end
			burh_pkg::CMD_TRIM: begin
				stack_trim(UNDO_SIDE);
				stack_trim(REDO_SIDE);
			end
			burh_pkg::CMD_SET: hist_now = w;
			default: ;
		endcase
		r.current = hist_now;
		r.undo_n  = 7'(hist_fill[UNDO_SIDE]);
		r.redo_n  = 7'(hist_fill[REDO_SIDE]);
		r.moved   = restored;
		return r;
	endfunction

	function automatic logic [2:0] pick_op(int mode);
		int roll;
		int acc;
		roll = $urandom_range(0, 99);
		acc = 0;
		for (int k = 0; k < 8; k++) begin
			acc += op_weight[mode][k];
			if (roll < acc) begin
				return 3'(k);
			end
		end
		return CMD_SPARE_7;
	endfunction

	// Extremes show up often so that all-zero and all-ones snapshots get
	// pushed, moved and restored, not just random patterns.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return 32'($urandom);
		endcase
	endfunction

	// Present one command word and hold it until the block takes it. The
	// shadow model is advanced at the accepting edge, so its view of the
	// limit always matches the block's.
	task automatic issue(logic [2:0] op, logic [31:0] w, logic typed, history_result_t want);
		history_result_t predicted;
		start <= 1'b1;
		cmd <= op;
		snapshot_word <= w;
		do @(posedge clk); while (busy);
		predicted = apply_command(op, w);
		if (typed) begin
			predicted = want;
		end
		pending_results = {pending_results, predicted};
	endtask

	// Sender pacing. Bursts of random length run back to back, with random
	// gaps between them. Now and then a long burst runs with no gap at all.
	// Random gap lengths land the next start on either phase of busy.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	// The limit is only changed with the block idle. Every command yields
	// exactly one result, so an empty queue of expected words means idle.
	task automatic write_limit(burh_pkg::limit_t value);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hist_limit = value;
	endtask

	task automatic compare_result(history_result_t want);
		if (current_word !== want.current) begin
			$error("current_word: expected %h, got %h", want.current, current_word);
			fail_count++;
		end
		if (undo_entries !== want.undo_n) begin
			$error("undo_entries: expected %0d, got %0d", want.undo_n, undo_entries);
			fail_count++;
		end
		if (redo_entries !== want.redo_n) begin
			$error("redo_entries: expected %0d, got %0d", want.redo_n, redo_entries);
			fail_count++;
		end
		if (moved !== want.moved) begin
			$error("moved: expected %0d, got %0d", want.moved, moved);
			fail_count++;
		end
	endtask

	// Results cannot be held off, so every done pulse is checked at the edge
	// that closes its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: current_word %h", current_word);
				fail_count++;
			end else begin
				compare_result(pending_results[0]);
				pending_results.delete(0);
			end
		end
	end

	// Ends the run when nothing at all is moving for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int lim;
		plan_row_t row;
		stack_empty(UNDO_SIDE);
		stack_empty(REDO_SIDE);
		hist_now = '0;
		hist_limit = burh_pkg::LIMIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			row = directed_plan[i];
			if (row.cfg_row) begin
				write_limit(burh_pkg::limit_t'(row.word));
			end else begin
				issue(row.op, row.word, row.typed, row.want);
				pace();
			end
		end

		// Each phase starts from whatever the previous one left in the stacks,
		// so a fill phase is followed by phases that drain or trim deep stacks.
		for (int p = 0; p < PHASES; p++) begin
			lim = (p == PHASES - 1) ? $urandom_range(0, 127) : phase_limit[p];
			write_limit(burh_pkg::limit_t'(lim));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				issue(pick_op(phase_mode[p]), pick_word(), 1'b0, '0);
				pace();
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
